// ===== design/pwp_pkg.sv =====
// shared types, constants and helper functions for the wallpaper pixel generator
`timescale 1ns / 1ps
package pwp_pkg;

  localparam int CoordW   = 11;
  localparam int SizeW    = 12;
  localparam int SeedW    = 32;
  localparam int ColorW   = 24;
  localparam int NumW     = CoordW + 13;
  localparam int NormW    = NumW;
  localparam int CfgIdxW  = 2;

  localparam int unsigned LcgMul     = 32'd1103515245;
  localparam int unsigned LcgAdd     = 32'd12345;
  localparam int unsigned OctaveStep = 32'h009E3779;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SEED   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SizeW-1:0] rem;
    logic [NumW-1:0]  work;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t cur, logic [SizeW-1:0] dv);
    logic [SizeW:0] sh;
    div_stage_t     nxt;
    sh = {cur.rem, cur.work[NumW-1]};
    if (sh >= {1'b0, dv}) begin
      nxt.rem  = SizeW'(sh - {1'b0, dv});
      nxt.work = {cur.work[NumW-2:0], 1'b1};
    end else begin
      nxt.rem  = sh[SizeW-1:0];
      nxt.work = {cur.work[NumW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic logic [5:0] bayer(logic [5:0] idx);
    logic [5:0] v;
    unique case (idx)
      6'd0: v = 6'd0;    6'd1: v = 6'd48;   6'd2: v = 6'd12;   6'd3: v = 6'd60;
      6'd4: v = 6'd3;    6'd5: v = 6'd51;   6'd6: v = 6'd15;   6'd7: v = 6'd63;
      6'd8: v = 6'd32;   6'd9: v = 6'd16;   6'd10: v = 6'd44;  6'd11: v = 6'd28;
      6'd12: v = 6'd35;  6'd13: v = 6'd19;  6'd14: v = 6'd47;  6'd15: v = 6'd31;
      6'd16: v = 6'd8;   6'd17: v = 6'd56;  6'd18: v = 6'd4;   6'd19: v = 6'd52;
      6'd20: v = 6'd11;  6'd21: v = 6'd59;  6'd22: v = 6'd7;   6'd23: v = 6'd55;
      6'd24: v = 6'd40;  6'd25: v = 6'd24;  6'd26: v = 6'd36;  6'd27: v = 6'd20;
      6'd28: v = 6'd43;  6'd29: v = 6'd27;  6'd30: v = 6'd39;  6'd31: v = 6'd23;
      6'd32: v = 6'd2;   6'd33: v = 6'd50;  6'd34: v = 6'd14;  6'd35: v = 6'd62;
      6'd36: v = 6'd1;   6'd37: v = 6'd49;  6'd38: v = 6'd13;  6'd39: v = 6'd61;
      6'd40: v = 6'd34;  6'd41: v = 6'd18;  6'd42: v = 6'd46;  6'd43: v = 6'd30;
      6'd44: v = 6'd33;  6'd45: v = 6'd17;  6'd46: v = 6'd45;  6'd47: v = 6'd29;
      6'd48: v = 6'd10;  6'd49: v = 6'd58;  6'd50: v = 6'd6;   6'd51: v = 6'd54;
      6'd52: v = 6'd9;   6'd53: v = 6'd57;  6'd54: v = 6'd5;   6'd55: v = 6'd53;
      6'd56: v = 6'd42;  6'd57: v = 6'd26;  6'd58: v = 6'd38;  6'd59: v = 6'd22;
      6'd60: v = 6'd41;  6'd61: v = 6'd25;  6'd62: v = 6'd37;  6'd63: v = 6'd21;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/procedural_wallpaper_pixel.sv =====
// procedural wallpaper pixel generator, top level
// throughput: one pixel per cycle while the output is not stalled; the two 24-stage restoring dividers set the depth
// a stalled output freezes the whole pipeline; input stall follows it in the same cycle
// synchronous active-low reset clears valid bits and loads the register reset values
`timescale 1ns / 1ps
module procedural_wallpaper_pixel #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pwp_pkg::CoordW-1:0]    in_column,
  input  logic [pwp_pkg::CoordW-1:0]    in_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pwp_pkg::ColorW-1:0]    out_pixel_color,
  input  logic                          cfg_we,
  input  logic [pwp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pwp_pkg::SeedW-1:0]     cfg_wdata
);
  import pwp_pkg::*;

  localparam int NDiv = NumW;
  localparam logic [12:0] MaxXm1 = 13'(MAX_WIDTH - 1);
  localparam logic [12:0] MaxYm1 = 13'(MAX_HEIGHT - 1);

  logic [SizeW-1:0] width_r, height_r;
  logic [SeedW-1:0] seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SizeW'(1024);
      height_r <= SizeW'(768);
      seed_r   <= 32'd218581527;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[SizeW-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[SizeW-1:0];
        REG_SEED:   seed_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic [SizeW-1:0] dvx, dvy;
  assign dvx = (width_r == '0) ? SizeW'(1) : width_r;
  assign dvy = (height_r == '0) ? SizeW'(1) : height_r;

  // stage 0: coordinate capture
  logic              v0_r;
  logic [CoordW-1:0] x0_r, y0_r;
  logic [CoordW-1:0] xs, ys;
  assign xs = ({2'b0, in_column} > MaxXm1) ? MaxXm1[CoordW-1:0] : in_column;
  assign ys = ({2'b0, in_row} > MaxYm1) ? MaxYm1[CoordW-1:0] : in_row;

  // divider stages
  div_stage_t        dx_r [1:NDiv];
  div_stage_t        dy_r [1:NDiv];
  div_stage_t        dx_nxt [1:NDiv];
  div_stage_t        dy_nxt [1:NDiv];
  logic [CoordW-1:0] px_r [1:NDiv];
  logic [CoordW-1:0] py_r [1:NDiv];
  logic              dv_r [1:NDiv];
  div_stage_t        startx, starty;

  always_comb begin
    startx.rem  = '0;
    startx.work = {x0_r, 13'd0} | NumW'(dvx[SizeW-1:1]);
    starty.rem  = '0;
    starty.work = {y0_r, 13'd0} | NumW'(dvy[SizeW-1:1]);
    dx_nxt[1] = div_step(startx, dvx);
    dy_nxt[1] = div_step(starty, dvy);
    for (int k = 2; k <= NDiv; k++) begin
      dx_nxt[k] = div_step(dx_r[k-1], dvx);
      dy_nxt[k] = div_step(dy_r[k-1], dvy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 1; k <= NDiv; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      v0_r    <= in_valid;
      dv_r[1] <= v0_r;
      for (int k = 2; k <= NDiv; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= xs;
      y0_r    <= ys;
      px_r[1] <= x0_r;
      py_r[1] <= y0_r;
      for (int k = 2; k <= NDiv; k++) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
      for (int k = 1; k <= NDiv; k++) begin
        dx_r[k] <= dx_nxt[k];
        dy_r[k] <= dy_nxt[k];
      end
    end
  end

  // stage a: gradient base, octave coordinates, dither, centre offsets
  logic [NormW-1:0]   nx, ny;
  logic [27:0]        base_sum;
  logic [25:0]        sx0, sy0, sx1, sy1, sx2, sy2;
  logic [7:0]         s8, s8b;
  logic               va_r;
  logic [7:0]         base_a_r, d_a_r;
  logic [23:0]        sxa_r [0:2];
  logic [23:0]        sya_r [0:2];
  logic signed [12:0] cx_r, cy_r;

  assign nx  = dx_r[NDiv].work;
  assign ny  = dy_r[NDiv].work;
  assign s8  = seed_r[7:0];
  assign s8b = seed_r[15:8];
  assign base_sum = 28'(nx) * 28'd5 + 28'(ny) * 28'd9 + 28'(s8);
  assign sx0 = 26'(nx) + 26'(s8);
  assign sy0 = 26'(ny) + 26'(s8b);
  assign sx1 = 26'((sx0 + 26'(ny[NormW-1:2])) >> 1);
  assign sy1 = 26'((sy0 + 26'(nx[NormW-1:2])) >> 1);
  assign sx2 = 26'((sx1 + 26'(ny[NormW-1:2])) >> 1);
  assign sy2 = 26'((sy1 + 26'(nx[NormW-1:2])) >> 1);

  // stage b: octave hashes, glow distance
  logic             vb_r;
  logic [7:0]       base_b_r, d_b_r, d2_b_r;
  logic [23:0]      hb_r [0:2];
  logic [25:0]      sqx, sqy;
  logic [22:0]      sqsum;

  assign sqx   = 26'($signed({{13{cx_r[12]}}, cx_r}) * $signed({{13{cx_r[12]}}, cx_r}));
  assign sqy   = 26'($signed({{13{cy_r[12]}}, cy_r}) * $signed({{13{cy_r[12]}}, cy_r}));
  assign sqsum = 23'(sqx + sqy);

  // stage c: lcg bytes
  logic       vc_r;
  logic [7:0] base_c_r, d_c_r, d2_c_r;
  logic [7:0] lc_r [0:2];

  // stage d: field value
  logic       vd_r;
  logic [7:0] f_d_r, d_d_r, d2_d_r;
  logic [7:0] acc;
  logic [8:0] fsum;
  assign acc  = {3'b0, lc_r[0][7:3]} + {4'b0, lc_r[1][7:4]} + {5'b0, lc_r[2][7:5]};
  assign fsum = 9'(base_c_r) + 9'(acc[7:1]);

  // stage e: color slopes
  logic        ve_r;
  logic [7:0]  r_e_r, g_e_r, b_e_r, d_e_r, d2_e_r;
  logic [15:0] rp, gp, bp;
  assign rp = 16'(f_d_r) * 16'd80  + 16'(d_d_r);
  assign gp = 16'(f_d_r) * 16'd144 + 16'(d_d_r);
  assign bp = 16'(f_d_r) * 16'd112 + 16'(d_d_r);

  // output stage: glow blend and pack
  logic [7:0]  ginv;
  logic [16:0] gt;
  logic [8:0]  gsum;
  logic [7:0]  gfin;
  logic [ColorW-1:0] color_r;
  assign ginv = 8'd255 - g_e_r;
  assign gt   = 17'(ginv) * 17'(d2_e_r) + 17'd128 + 17'(d_e_r);
  assign gsum = 9'(g_e_r) + 9'(gt[15:8]);
  assign gfin = gsum[8] ? 8'd255 : gsum[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= dv_r[NDiv];
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      out_valid_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_a_r <= (|base_sum[27:13]) ? 8'd255 : base_sum[12:5];
      d_a_r    <= {bayer({py_r[NDiv][2:0], px_r[NDiv][2:0]}), 2'b10};
      sxa_r[0] <= sx0[23:0];
      sxa_r[1] <= sx1[23:0];
      sxa_r[2] <= sx2[23:0];
      sya_r[0] <= sy0[23:0];
      sya_r[1] <= sy1[23:0];
      sya_r[2] <= sy2[23:0];
      cx_r     <= $signed({2'b0, width_r[SizeW-1:1]}) - $signed({2'b0, px_r[NDiv]});
      cy_r     <= $signed({2'b0, height_r[SizeW-1:1]}) - $signed({2'b0, py_r[NDiv]});

      base_b_r <= base_a_r;
      d_b_r    <= d_a_r;
      d2_b_r   <= (|sqsum[22:20]) ? 8'd255 : sqsum[19:12];
      for (int i = 0; i < 3; i++) begin
        hb_r[i] <= 24'(sxa_r[i] * 24'd73 + sya_r[i] * 24'd151 + seed_r[23:0]
                   + 24'(OctaveStep * 32'(i)));
      end

      base_c_r <= base_b_r;
      d_c_r    <= d_b_r;
      d2_c_r   <= d2_b_r;
      for (int i = 0; i < 3; i++) begin
        lc_r[i] <= 8'((24'(hb_r[i] * LcgMul[23:0]) + LcgAdd[23:0]) >> 16);
      end

      f_d_r  <= fsum[8] ? 8'd255 : fsum[7:0];
      d_d_r  <= d_c_r;
      d2_d_r <= d2_c_r;

      r_e_r  <= 8'd12 + rp[15:8];
      g_e_r  <= 8'd40 + gp[15:8];
      b_e_r  <= 8'd72 + bp[15:8];
      d_e_r  <= d_d_r;
      d2_e_r <= d2_d_r;

      color_r <= {r_e_r, gfin, b_e_r};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;

  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("input stall mismatch");
  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_color[23:16] >= 8'd12 && out_pixel_color[23:16] <= 8'd92))
    else $error("red out of range");
  a_blue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_color[7:0] >= 8'd72 && out_pixel_color[7:0] <= 8'd184))
    else $error("blue out of range");
  a_green_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_color[15:8] >= 8'd40) else $error("green below base");

endmodule
